// File: design/assert_macros.svh
// Assertion macros for the port-level checker jsoes_checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define JSOES_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jsoes assertion failed");

// Next-cycle implication, disabled while rst is high.
`define JSOES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jsoes assertion failed");

`endif

// File: design/jsoes_pkg.sv
// Package for the JS object extent scanner: sizes, context and status codes,
// character constants and byte classification functions. No dependencies.
package jsoes_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int LENGTH_BITS = 20;
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

   typedef enum logic [2:0] {
      CTX_BRACE   = 3'd0,
      CTX_BRACKET = 3'd1,
      CTX_DQUOTE  = 3'd2,
      CTX_SQUOTE  = 3'd3,
      CTX_SLASH   = 3'd4
   } ctx_type;

   typedef enum logic [2:0] {
      ST_SCANNING     = 3'd0,
      ST_COMPLETE     = 3'd1,
      ST_INVALID      = 3'd2,
      ST_IDLE         = 3'd3,
      ST_OVERFLOW     = 3'd4,
      ST_UNTERMINATED = 3'd5
   } status_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stk_ctrl_type;

   typedef struct packed {
      status_type             status;
      logic [LENGTH_BITS-1:0] length;
   } rsp_item_type;

   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_RBRACKET  = 8'h5D;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_EQUAL     = 8'h3D;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_BANG      = 8'h21;
   localparam logic [7:0] CH_AMP       = 8'h26;
   localparam logic [7:0] CH_PIPE      = 8'h7C;
   localparam logic [7:0] CH_QUESTION  = 8'h3F;
   localparam logic [7:0] CH_SEMI      = 8'h3B;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;

   function automatic logic [7:0] closer_of(input ctx_type ctx);
      logic [7:0] c;
      case (ctx)
         CTX_BRACE:   c = CH_RBRACE;
         CTX_BRACKET: c = CH_RBRACKET;
         CTX_DQUOTE:  c = CH_DQUOTE;
         CTX_SQUOTE:  c = CH_SQUOTE;
         CTX_SLASH:   c = CH_SLASH;
         default:     c = CH_RBRACE;
      endcase
      return c;
   endfunction

   function automatic logic is_opener(input logic [7:0] c);
      return c inside {CH_LBRACE, CH_LBRACKET, CH_DQUOTE, CH_SQUOTE, CH_SLASH};
   endfunction

   function automatic ctx_type opener_ctx(input logic [7:0] c);
      ctx_type ctx;
      case (c)
         CH_LBRACKET: ctx = CTX_BRACKET;
         CH_DQUOTE:   ctx = CTX_DQUOTE;
         CH_SQUOTE:   ctx = CTX_SQUOTE;
         CH_SLASH:    ctx = CTX_SLASH;
         default:     ctx = CTX_BRACE;
      endcase
      return ctx;
   endfunction

   function automatic logic regex_may_follow(input logic [7:0] c);
      return c inside {CH_LPAREN, CH_COMMA, CH_EQUAL, CH_COLON, CH_LBRACKET, CH_BANG,
                       CH_AMP, CH_PIPE, CH_QUESTION, CH_LBRACE, CH_RBRACE, CH_SEMI};
   endfunction

endpackage

// File: design/jsoes_cell.sv
// One entry of the context stack; shifts toward the bottom on push and
// toward the top on pop. Depends on jsoes_pkg.
module jsoes_cell
   import jsoes_pkg::*;
(
   input  logic         clock,
   input  stk_ctrl_type ctrl,
   input  ctx_type      up_ctx,
   input  ctx_type      down_ctx,
   output ctx_type      ctx
);

   ctx_type ctx_ff;

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         ctx_ff <= up_ctx;
      end else if (ctrl.pop) begin
         ctx_ff <= down_ctx;
      end
   end

   assign ctx = ctx_ff;

endmodule

// File: design/jsoes_stack.sv
// Context stack built as a chain of jsoes_cell; the top of stack always
// sits in cell 0. Depends on jsoes_pkg and jsoes_cell.
module jsoes_stack
   import jsoes_pkg::*;
(
   input  logic         clock,
   input  stk_ctrl_type ctrl,
   input  ctx_type      push_ctx,
   output ctx_type      top_ctx
);

   ctx_type chain [STACK_DEPTH];

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      ctx_type up_ctx;
      ctx_type down_ctx;

      if (i == 0) begin : g_first
         assign up_ctx = push_ctx;
      end else begin : g_mid
         assign up_ctx = chain[i-1];
      end

      // bottom cell keeps its value on pop; that slot is dead anyway
      if (i == STACK_DEPTH - 1) begin : g_last
         assign down_ctx = chain[i];
      end else begin : g_rest
         assign down_ctx = chain[i+1];
      end

      jsoes_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .up_ctx   (up_ctx),
         .down_ctx (down_ctx),
         .ctx      (chain[i])
      );
   end

   assign top_ctx = chain[0];

endmodule

// File: design/jsoes_rsp_buf.sv
// Two-entry output buffer (head plus skid register) for result beats.
// Depends on jsoes_pkg.
module jsoes_rsp_buf
   import jsoes_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  rsp_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   logic         head_v_ff, head_v_in;
   logic         skid_v_ff, skid_v_in;
   rsp_item_type head_ff, head_in;
   rsp_item_type skid_ff, skid_in;
   logic         pop;
   logic         push;

   assign pop  = head_v_ff && out_ready;
   assign push = in_valid && !skid_v_ff;

   always_comb begin
      head_v_in = head_v_ff;
      skid_v_in = skid_v_ff;
      head_in   = head_ff;
      skid_in   = skid_ff;
      if (!head_v_ff) begin
         if (push) begin
            head_in   = in_item;
            head_v_in = 1'b1;
         end
      end else if (!skid_v_ff) begin
         if (pop && push) begin
            head_in = in_item;
         end else if (pop) begin
            head_v_in = 1'b0;
         end else if (push) begin
            skid_in   = in_item;
            skid_v_in = 1'b1;
         end
      end else if (pop) begin
         head_in   = skid_ff;
         skid_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         head_v_ff <= head_v_in;
         skid_v_ff <= skid_v_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign in_ready  = !skid_v_ff;
   assign out_valid = head_v_ff;
   assign out_item  = head_ff;

endmodule

// File: design/js_object_extent_scanner.sv
// Output: the result beat for an accepted byte is registered in the output buffer.
// Throughput: one byte per cycle while req_ready is high; the top-of-stack compare
// and push or pop of the 64-cell shift chain both finish in the cycle it is taken.
// Reset: synchronous, active high; clears scan control and the output buffer,
// stack cell contents are not cleared and need no clearing pass.
module js_object_extent_scanner
   import jsoes_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_text_byte,
   input  logic                   req_first_byte,
   input  logic                   req_end_of_text,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_scan_status,
   output logic [LENGTH_BITS-1:0] rsp_object_length
);

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

   logic               active_ff, active_in;
   logic               skip_ff, skip_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [7:0]         last_ff, last_in;
   logic [7:0]         prev_ff, prev_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;

   logic         accept;
   stk_ctrl_type stk_op;
   stk_ctrl_type stk_ctrl;
   ctx_type      push_ctx;
   ctx_type      top_ctx;
   rsp_item_type item;
   rsp_item_type out_item;
   logic         is_quote_ctx;
   logic         take_open;

   assign accept       = req_valid && req_ready;
   assign is_quote_ctx = top_ctx inside {CTX_DQUOTE, CTX_SQUOTE, CTX_SLASH};

   always_comb begin
      active_in   = active_ff;
      skip_in     = skip_ff;
      depth_in    = depth_ff;
      last_in     = last_ff;
      prev_in     = prev_ff;
      count_in    = count_ff;
      stk_op      = '0;
      push_ctx    = opener_ctx(req_text_byte);
      item.status = ST_SCANNING;
      item.length = '0;
      take_open   = 1'b0;

      if (req_first_byte) begin
         if (!(req_text_byte == CH_LBRACE || req_text_byte == CH_LBRACKET)) begin
            active_in   = 1'b0;
            depth_in    = '0;
            skip_in     = 1'b0;
            item.status = ST_INVALID;
         end else begin
            stk_op.push = 1'b1;
            depth_in    = DEPTH_W'(1);
            count_in    = LENGTH_BITS'(1);
            prev_in     = req_text_byte;
            last_in     = req_text_byte;
            skip_in     = 1'b0;
            active_in   = 1'b1;
         end
      end else if (!active_ff) begin
         item.status = ST_IDLE;
      end else begin
         if (count_ff != LEN_MAX) begin
            count_in = count_ff + LENGTH_BITS'(1);
         end
         if (skip_ff) begin
            skip_in = 1'b0;
         end else begin
            if (prev_ff != CH_SPACE && prev_ff != CH_NEWLINE) begin
               last_in = prev_ff;
            end
            prev_in = req_text_byte;
            if (req_text_byte == closer_of(top_ctx)) begin
               stk_op.pop = 1'b1;
               depth_in   = depth_ff - DEPTH_W'(1);
               if (depth_ff == DEPTH_W'(1)) begin
                  active_in   = 1'b0;
                  item.status = ST_COMPLETE;
               end
            end else if (is_quote_ctx) begin
               if (req_text_byte == CH_BACKSLASH) begin
                  skip_in = 1'b1;
               end
            end else begin
               // a slash only opens a regex after certain punctuation
               take_open = is_opener(req_text_byte) &&
                  !(req_text_byte == CH_SLASH && !regex_may_follow(last_in));
               if (take_open) begin
                  if (depth_ff == DEPTH_W'(STACK_DEPTH)) begin
                     active_in   = 1'b0;
                     item.status = ST_OVERFLOW;
                  end else begin
                     stk_op.push = 1'b1;
                     depth_in    = depth_ff + DEPTH_W'(1);
                  end
               end
            end
         end
      end

      if (item.status != ST_INVALID && item.status != ST_IDLE) begin
         item.length = count_in;
         if (active_in && req_end_of_text) begin
            active_in   = 1'b0;
            item.status = ST_UNTERMINATED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         skip_ff   <= 1'b0;
         depth_ff  <= '0;
         last_ff   <= '0;
         prev_ff   <= '0;
         count_ff  <= '0;
      end else if (accept) begin
         active_ff <= active_in;
         skip_ff   <= skip_in;
         depth_ff  <= depth_in;
         last_ff   <= last_in;
         prev_ff   <= prev_in;
         count_ff  <= count_in;
      end
   end

   assign stk_ctrl.push = stk_op.push && accept;
   assign stk_ctrl.pop  = stk_op.pop && accept;

   jsoes_stack u_stack (
      .clock    (clock),
      .ctrl     (stk_ctrl),
      .push_ctx (push_ctx),
      .top_ctx  (top_ctx)
   );

   jsoes_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (item),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (out_item)
   );

   assign rsp_scan_status   = out_item.status;
   assign rsp_object_length = out_item.length;

endmodule

// File: design/jsoes_checker.sv
// Port-level checker for js_object_extent_scanner, bound to the top level.
// Depends on jsoes_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jsoes_checker
   import jsoes_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [7:0]             req_text_byte,
   input logic                   req_first_byte,
   input logic                   req_end_of_text,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [2:0]             rsp_scan_status,
   input logic [LENGTH_BITS-1:0] rsp_object_length
);

   // stalled result beat holds
   `JSOES_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_scan_status) && $stable(rsp_object_length))

   // rejected starts and idle bytes report no length
   `JSOES_ASSERT_SAME(a_zero_len, clock, reset, rsp_valid && (rsp_scan_status == ST_INVALID || rsp_scan_status == ST_IDLE), rsp_object_length == '0)

   // a completed object spans at least opener and closer
   `JSOES_ASSERT_SAME(a_complete_len, clock, reset, rsp_valid && rsp_scan_status == ST_COMPLETE, rsp_object_length >= LENGTH_BITS'(2))

   // nothing is shown in the cycle after reset
   `JSOES_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && req_ready)

endmodule

bind js_object_extent_scanner jsoes_checker u_checker (.*);

// File: tb/jsoes_extent_checker.sv
`timescale 1ns / 100ps
// Checker for js_object_extent_scanner: watches the byte and result channels,
// predicts the status and length of every result beat and compares them.
// Depends on jsoes_pkg for sizes, status and context codes and byte constants.
module jsoes_extent_checker
   import jsoes_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [7:0]             req_text_byte,
   input  logic                   req_first_byte,
   input  logic                   req_end_of_text,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [2:0]             rsp_scan_status,
   input  logic [LENGTH_BITS-1:0] rsp_object_length,
   output int                     mismatch_count,
   output int                     pending_count
);

   localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;
   localparam int                     IDX_W      = $clog2(STACK_DEPTH);

   ctx_type                ctx_stack [STACK_DEPTH];
   logic [DEPTH_W-1:0]     depth;
   logic [7:0]             last_sig;
   logic [7:0]             prev_byte;
   logic                   skip_byte;
   logic [LENGTH_BITS-1:0] byte_count;
   logic                   scan_active;
   rsp_item_type           expected_extents [$];
   int                     mismatches = 0;
   int                     waiting = 0;

   assign mismatch_count = mismatches;
   assign pending_count  = waiting;

   function automatic rsp_item_type advance_scan(input logic [7:0] c, input logic first,
                                                 input logic eot);
      rsp_item_type res;
      ctx_type      top;
      ctx_type      open_ctx;
      logic [7:0]   closer;
      logic         opens;
      logic         regex_ok;
      res.status = ST_SCANNING;
      res.length = '0;
      if (first) begin
         if (c != CH_LBRACE && c != CH_LBRACKET) begin
            scan_active = 1'b0;
            depth       = '0;
            skip_byte   = 1'b0;
            res.status  = ST_INVALID;
            return res;
         end
         ctx_stack[0] = (c == CH_LBRACE) ? CTX_BRACE : CTX_BRACKET;
         depth       = DEPTH_W'(1);
         byte_count  = LENGTH_BITS'(1);
         prev_byte   = c;
         last_sig    = c;
         skip_byte   = 1'b0;
         scan_active = 1'b1;
      end else begin
         if (!scan_active) begin
            res.status = ST_IDLE;
            return res;
         end
         if (byte_count != LENGTH_MAX) byte_count++;
         if (skip_byte) begin
            // escaped byte: counted, otherwise invisible
            skip_byte = 1'b0;
         end else begin
            if (prev_byte != CH_SPACE && prev_byte != CH_NEWLINE) last_sig = prev_byte;
            prev_byte = c;
            if (depth == 0 || depth > STACK_DEPTH) begin
               scan_active = 1'b0;
               res.status  = ST_COMPLETE;
               res.length  = byte_count;
               return res;
            end
            top = ctx_stack[IDX_W'(depth - DEPTH_W'(1))];
            case (top)
               CTX_BRACKET: closer = CH_RBRACKET;
               CTX_DQUOTE:  closer = CH_DQUOTE;
               CTX_SQUOTE:  closer = CH_SQUOTE;
               CTX_SLASH:   closer = CH_SLASH;
               default:     closer = CH_RBRACE;
            endcase
            opens = 1'b1;
            open_ctx = CTX_BRACE;
            case (c)
               CH_LBRACE:   open_ctx = CTX_BRACE;
               CH_LBRACKET: open_ctx = CTX_BRACKET;
               CH_DQUOTE:   open_ctx = CTX_DQUOTE;
               CH_SQUOTE:   open_ctx = CTX_SQUOTE;
               CH_SLASH:    open_ctx = CTX_SLASH;
               default:     opens = 1'b0;
            endcase
            case (last_sig)
               CH_LPAREN, CH_COMMA, CH_EQUAL, CH_COLON, CH_LBRACKET, CH_BANG,
               CH_AMP, CH_PIPE, CH_QUESTION, CH_LBRACE, CH_RBRACE, CH_SEMI:
                  regex_ok = 1'b1;
               default:
                  regex_ok = 1'b0;
            endcase
            if (c == closer) begin
               depth--;
               if (depth == 0) begin
                  scan_active = 1'b0;
                  res.status  = ST_COMPLETE;
               end
            end else if (top != CTX_BRACE && top != CTX_BRACKET) begin
               if (c == CH_BACKSLASH) skip_byte = 1'b1;
            end else if (opens && (c != CH_SLASH || regex_ok)) begin
               if (depth >= STACK_DEPTH) begin
                  scan_active = 1'b0;
                  res.status  = ST_OVERFLOW;
               end else begin
                  ctx_stack[IDX_W'(depth)] = open_ctx;
                  depth++;
               end
            end
         end
      end
      if (scan_active && eot) begin
         scan_active = 1'b0;
         res.status  = ST_UNTERMINATED;
      end
      res.length = byte_count;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rsp_item_type want;
      if (reset) begin
         depth       = '0;
         last_sig    = '0;
         prev_byte   = '0;
         skip_byte   = 1'b0;
         byte_count  = '0;
         scan_active = 1'b0;
         expected_extents.delete();
      end else begin
         // a result beat belongs to an older byte, so compare before predicting
         if (rsp_valid && rsp_ready) begin
            if (expected_extents.size() == 0) begin
               $error("unexpected result beat: scan_status %0d object_length %0d",
                      rsp_scan_status, rsp_object_length);
               mismatches++;
            end else begin
               want = expected_extents.pop_front();
               if (rsp_scan_status !== want.status) begin
                  $error("scan_status: expected %0d, actual %0d", want.status,
                         rsp_scan_status);
                  mismatches++;
               end
               if (rsp_object_length !== want.length) begin
                  $error("object_length: expected %0d, actual %0d", want.length,
                         rsp_object_length);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_extents.insert(expected_extents.size(),
                                    advance_scan(req_text_byte, req_first_byte,
                                                 req_end_of_text));
      end
      waiting = expected_extents.size();
   end

endmodule

// File: tb/tb_js_object_extent_scanner.sv
`timescale 1ns / 100ps
// Testbench top for js_object_extent_scanner: clock, reset, text byte stimulus
// and result back-pressure. Depends on jsoes_pkg and jsoes_extent_checker.
module tb_js_object_extent_scanner;
   import jsoes_pkg::*;

   localparam int         CYCLE_LIMIT       = 200_000;
   localparam int         BYTES_PER_PHASE   = 350;
   localparam int         LONG_STALL_CYCLES = 300;
   localparam logic [7:0] LETTER_A          = 8'h61;
   localparam logic [7:0] DIGIT_0           = 8'h30;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [7:0]             req_text_byte;
   logic                   req_first_byte;
   logic                   req_end_of_text;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [2:0]             rsp_scan_status;
   logic [LENGTH_BITS-1:0] rsp_object_length;

   int         mismatch_count;
   int         pending_count;
   int         send_idle_pct = 23;
   int         recv_idle_pct = 86;
   bit         long_stall_req = 1'b0;
   int         phase_bytes;
   int         cycle_count;
   logic [7:0] text_q [$];

   js_object_extent_scanner i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_text_byte     (req_text_byte),
      .req_first_byte    (req_first_byte),
      .req_end_of_text   (req_end_of_text),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_scan_status   (rsp_scan_status),
      .rsp_object_length (rsp_object_length)
   );

   jsoes_extent_checker i_extent_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_text_byte     (req_text_byte),
      .req_first_byte    (req_first_byte),
      .req_end_of_text   (req_end_of_text),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_scan_status   (rsp_scan_status),
      .rsp_object_length (rsp_object_length),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // result side: random stalls plus one long hold-off on request
   initial begin
      int stall_left;
      bit stall_taken;
      rsp_ready   = 1'b0;
      stall_left  = 0;
      stall_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (long_stall_req && !stall_taken) begin
            stall_taken = 1'b1;
            stall_left  = LONG_STALL_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the beat
   task automatic send_byte(input logic [7:0] c, input bit first, input bit eot,
                            input bit counted);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_text_byte   = c;
      req_first_byte  = first;
      req_end_of_text = eot;
      do @(posedge clock); while (!req_ready);
      if (counted) phase_bytes++;
      @(negedge clock);
   endtask

   task automatic send_text(input bit with_start, input bit eot_last, input bit counted);
      for (int i = 0; i < text_q.size(); i++)
         send_byte(text_q[i], with_start && i == 0, eot_last && i == text_q.size() - 1,
                   counted);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic put_byte(input logic [7:0] b);
      text_q.insert(text_q.size(), b);
   endtask

   task automatic put_string(input string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      case ($urandom_range(11))
         0:       return CH_RBRACE;
         1:       return CH_RBRACKET;
         2:       return CH_DQUOTE;
         3:       return CH_SQUOTE;
         4:       return CH_SLASH;
         5:       return CH_BACKSLASH;
         6:       return CH_LBRACE;
         7:       return CH_LBRACKET;
         8:       return CH_SPACE;
         9:       return CH_COMMA;
         default: return b;
      endcase
   endfunction

   task automatic put_filler();
      case ($urandom_range(5))
         0:       put_byte(CH_SPACE);
         1:       put_byte(CH_NEWLINE);
         default: ;
      endcase
   endtask

   // quote or regex body with random bytes and escapes
   task automatic put_quoted(input logic [7:0] quote);
      int         n;
      logic [7:0] b;
      n = $urandom_range(6);
      put_byte(quote);
      repeat (n) begin
         b = 8'($urandom_range(255));
         if (b == CH_BACKSLASH || $urandom_range(7) == 0) begin
            put_byte(CH_BACKSLASH);
            b = 8'($urandom_range(255));
            put_byte(b);
         end else if (b != quote) begin
            put_byte(b);
         end
      end
      put_byte(quote);
   endtask

   // every caller sits in a value position, where a regex literal may follow
   task automatic put_value(input int level, input bit container);
      int         kind;
      int         n;
      logic [7:0] b;
      if (container) kind = $urandom_range(1);
      else if (level >= 3) kind = $urandom_range(2, 6);
      else kind = $urandom_range(6);
      case (kind)
         0: begin
            put_byte(CH_LBRACE);
            n = $urandom_range(3);
            for (int i = 0; i < n; i++) begin
               if (i > 0) put_byte(CH_COMMA);
               put_filler();
               put_quoted($urandom_range(1) ? CH_DQUOTE : CH_SQUOTE);
               put_byte(CH_COLON);
               put_filler();
               put_value(level + 1, 1'b0);
            end
            put_filler();
            put_byte(CH_RBRACE);
         end
         1: begin
            put_byte(CH_LBRACKET);
            n = $urandom_range(3);
            for (int i = 0; i < n; i++) begin
               if (i > 0) put_byte(CH_COMMA);
               put_filler();
               put_value(level + 1, 1'b0);
            end
            put_filler();
            put_byte(CH_RBRACKET);
         end
         2: put_quoted(CH_DQUOTE);
         3: put_quoted(CH_SQUOTE);
         4: put_quoted(CH_SLASH);
         5: begin
            // word with division; a '/' after a letter or digit is no regex
            n = $urandom_range(4);
            b = LETTER_A + 8'($urandom_range(25));
            put_byte(b);
            repeat (n) begin
               if ($urandom_range(5) == 0) put_byte(CH_SLASH);
               b = $urandom_range(1) ? LETTER_A + 8'($urandom_range(25))
                                     : DIGIT_0 + 8'($urandom_range(9));
               put_byte(b);
            end
         end
         default: begin
            case ($urandom_range(7))
               0:       put_byte(CH_LPAREN);
               1:       put_byte(CH_EQUAL);
               2:       put_byte(CH_BANG);
               3:       put_byte(CH_AMP);
               4:       put_byte(CH_PIPE);
               5:       put_byte(CH_QUESTION);
               6:       put_byte(CH_SEMI);
               default: put_byte(CH_COMMA);
            endcase
            put_filler();
            put_quoted(CH_SLASH);
         end
      endcase
   endtask

   task automatic random_sequence(input int pick);
      int         n;
      logic [7:0] b;
      text_q.delete();
      if (pick < 72) begin
         put_value(0, 1'b1);
         if (pick < 62) begin
            send_text(1'b1, $urandom_range(7) == 0, 1'b1);
         end else begin
            // broken text: a few bytes overwritten
            n = $urandom_range(1, 3);
            repeat (n) text_q[$urandom_range(1, text_q.size() - 1)] = noise_byte();
            send_text(1'b1, $urandom_range(1), 1'b1);
         end
      end else if (pick < 85) begin
         // truncated: end of text inside the scan, or abandoned by the next start
         put_value(0, 1'b1);
         n = $urandom_range(1, text_q.size() - 1);
         text_q = text_q[0:n-1];
         send_text(1'b1, pick < 80, 1'b1);
      end else if (pick < 90) begin
         b = noise_byte();
         if (b == CH_LBRACE || b == CH_LBRACKET) b = CH_RBRACE;
         put_byte(b);
         send_text(1'b1, $urandom_range(1), 1'b1);
      end else if (pick < 94) begin
         n = $urandom_range(1, 3);
         repeat (n) put_byte(noise_byte());
         send_text(1'b0, $urandom_range(1), 1'b0);
      end else begin
         put_byte($urandom_range(1) ? CH_LBRACE : CH_LBRACKET);
         repeat (STACK_DEPTH - 1) put_byte($urandom_range(1) ? CH_LBRACE : CH_LBRACKET);
         if (pick < 97) begin
            // one push past a full stack, then bytes the idle block ignores
            put_byte($urandom_range(1) ? CH_LBRACE : CH_LBRACKET);
            put_byte(CH_RBRACE);
            put_byte(CH_RBRACKET);
         end else begin
            n = text_q.size();
            for (int i = n - 1; i >= 0; i--)
               put_byte(text_q[i] == CH_LBRACE ? CH_RBRACE : CH_RBRACKET);
         end
         send_text(1'b1, 1'b0, 1'b1);
      end
   endtask

   task automatic run_random_phase();
      phase_bytes = 0;
      while (phase_bytes < BYTES_PER_PHASE) random_sequence($urandom_range(99));
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_text_byte   = '0;
      req_first_byte  = 1'b0;
      req_end_of_text = 1'b0;
      cycle_count     = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: idle byte, bad start, empty object, whitespace before a regex
      // with a closer inside it, division and a stray closer, escaped quote,
      // a scan abandoned by a new start that ends on its opener
      text_q.delete(); put_string("x");        send_text(1'b0, 1'b0, 1'b0);
      text_q.delete(); put_string("a");        send_text(1'b1, 1'b0, 1'b1);
      text_q.delete(); put_string("{}");       send_text(1'b1, 1'b0, 1'b1);
      text_q.delete(); put_string("[ \n/]/]"); send_text(1'b1, 1'b0, 1'b1);
      text_q.delete(); put_string("{a/b]}");   send_text(1'b1, 1'b0, 1'b1);
      text_q.delete(); put_string("['\\'']");  send_text(1'b1, 1'b0, 1'b1);
      text_q.delete(); put_string("{\"x");     send_text(1'b1, 1'b0, 1'b1);
      text_q.delete(); put_string("[");        send_text(1'b1, 1'b1, 1'b1);

      // nesting to overflow and to exactly full
      random_sequence(95);
      random_sequence(98);
      run_random_phase();
      wait_drained();

      send_idle_pct = 86;
      recv_idle_pct = 23;
      run_random_phase();
      wait_drained();

      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      long_stall_req = 1'b1;
      run_random_phase();

      wait_drained();
      repeat (5) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+design
design/jsoes_pkg.sv
design/jsoes_cell.sv
design/jsoes_stack.sv
design/jsoes_rsp_buf.sv
design/js_object_extent_scanner.sv
design/jsoes_checker.sv
tb/jsoes_extent_checker.sv
tb/tb_js_object_extent_scanner.sv
